@@ design/i2p_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the infix to postfix converter.
package i2p_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CHAR_W      = 8;

  // Characters with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  // Operator precedence levels
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  // What the stack loop is doing for the current request
  typedef enum logic [1:0] {
    MODE_OP    = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_t;

  // One result as it sits in the hold or output register
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              has_char;
    status_t           status;
  } result_t;

  // Precedence of a character; parentheses and operands rank lowest
  function automatic logic [1:0] rank_of(input logic [CHAR_W-1:0] c);
    logic [1:0] r;
    r = RANK_NONE;
    if (c == CH_STAR || c == CH_SLASH) begin
      r = RANK_MUL;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = RANK_ADD;
    end
    return r;
  endfunction

  function automatic logic is_binop(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

endpackage

@@ design/i2p_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// Top level of the shunting-yard infix to postfix converter.

// Takes one infix ASCII character per request and returns postfix results
// through an operator stack held in a 32-entry synchronous RAM. One request is
// worked on at a time: a plain operand is accepted, emitted and closed, and
// every stack pop first issues the read of the top and then evaluates it, as
// the stack RAM has registered read data. A request marked end_of_expr then
// flushes the stack, popping each entry in the same way. Each result passes
// through a one-deep hold register so that the final result of an expression
// can be tagged with last; it leaves that register when the next result of the
// same request arrives or when the request closes. A full stack drops the push
// and reports overflow; a closing parenthesis without its opening one reports
// an unmatched parenthesis. No clearing pass is needed: only entries below the
// stack count are ever read.
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_expr,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       last,
  output logic [1:0] status
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EVAL = 7'b0000100,
    S_PUSH = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_FLAG = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                             state, state_next;
  i2p_pkg::mode_t                     mode, mode_next;
  logic [i2p_pkg::CNT_W-1:0]          count, count_next;
  logic [i2p_pkg::CHAR_W-1:0]         cur_char;
  logic                               cur_fin;
  i2p_pkg::status_t                   flag_status, flag_status_next;

  // Hold and output registers
  logic                               pend_valid;
  i2p_pkg::result_t                   pend;
  i2p_pkg::result_t                   out_res;
  logic                               out_last;

  // Stack RAM ports
  logic                               wr_en;
  logic [i2p_pkg::ADDR_W-1:0]         wr_addr;
  logic                               rd_en;
  logic [i2p_pkg::ADDR_W-1:0]         rd_addr;
  logic [i2p_pkg::CHAR_W-1:0]         top;

  // Emission into the hold register
  logic                               out_free;
  logic                               can_emit;
  logic                               emit_fire;
  i2p_pkg::result_t                   emit_res;
  logic                               close_fire;
  logic                               close_bare;
  logic                               stack_empty;
  logic                               stack_full;
  logic                               pop_ok;

  i2p_ram #(
    .WIDTH (i2p_pkg::CHAR_W),
    .DEPTH (i2p_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cur_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (top)
  );

  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign can_emit    = !pend_valid || out_free;
  assign stack_empty = (count == '0);
  assign stack_full  = (count == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
  assign wr_addr     = count[i2p_pkg::ADDR_W-1:0];
  assign rd_addr     = i2p_pkg::ADDR_W'(count - i2p_pkg::CNT_W'(1));
  assign pop_ok      = (i2p_pkg::rank_of(cur_char) <= i2p_pkg::rank_of(top));

  // Sequence one request through the stack
  always_comb begin
    state_next       = state;
    mode_next        = mode;
    count_next       = count;
    flag_status_next = flag_status;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    emit_fire        = 1'b0;
    emit_res         = '{out_char: top, has_char: 1'b1, status: i2p_pkg::ST_OK};
    close_fire       = 1'b0;
    close_bare       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (i2p_pkg::is_binop(ch)) begin
            mode_next  = i2p_pkg::MODE_OP;
            state_next = S_READ;
          end else if (ch == i2p_pkg::CH_OPEN) begin
            state_next = S_PUSH;
          end else if (ch == i2p_pkg::CH_CLOSE) begin
            mode_next  = i2p_pkg::MODE_CLOSE;
            state_next = S_READ;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_READ: begin
        if (!stack_empty) begin
          rd_en      = 1'b1;
          state_next = S_EVAL;
        end else begin
          case (mode)
            i2p_pkg::MODE_OP: state_next = S_PUSH;
            i2p_pkg::MODE_CLOSE: begin
              flag_status_next = i2p_pkg::ST_UNMATCHED;
              state_next       = S_FLAG;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_EVAL: begin
        case (mode)
          i2p_pkg::MODE_OP: begin
            if (!pop_ok) begin
              state_next = S_PUSH;
            end else if (can_emit) begin
              emit_fire  = 1'b1;
              count_next = count - i2p_pkg::CNT_W'(1);
              state_next = S_READ;
            end
          end
          i2p_pkg::MODE_CLOSE: begin
            if (top == i2p_pkg::CH_OPEN) begin
              // discard the matching opening parenthesis
              count_next = count - i2p_pkg::CNT_W'(1);
              mode_next  = i2p_pkg::MODE_FLUSH;
              state_next = cur_fin ? S_READ : S_DONE;
            end else if (can_emit) begin
              emit_fire  = 1'b1;
              count_next = count - i2p_pkg::CNT_W'(1);
              state_next = S_READ;
            end
          end
          default: begin
            if (can_emit) begin
              emit_fire  = 1'b1;
              count_next = count - i2p_pkg::CNT_W'(1);
              state_next = S_READ;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (stack_full) begin
          flag_status_next = i2p_pkg::ST_OVERFLOW;
          state_next       = S_FLAG;
        end else begin
          wr_en      = 1'b1;
          count_next = count + i2p_pkg::CNT_W'(1);
          mode_next  = i2p_pkg::MODE_FLUSH;
          state_next = cur_fin ? S_READ : S_DONE;
        end
      end
      S_EMIT: begin
        emit_res = '{out_char: cur_char, has_char: 1'b1, status: i2p_pkg::ST_OK};
        if (can_emit) begin
          emit_fire  = 1'b1;
          mode_next  = i2p_pkg::MODE_FLUSH;
          state_next = cur_fin ? S_READ : S_DONE;
        end
      end
      S_FLAG: begin
        emit_res = '{out_char: i2p_pkg::CH_NONE, has_char: 1'b0, status: flag_status};
        if (can_emit) begin
          emit_fire  = 1'b1;
          mode_next  = i2p_pkg::MODE_FLUSH;
          state_next = cur_fin ? S_READ : S_DONE;
        end
      end
      S_DONE: begin
        // release the held result, tagged last on an end request
        if (pend_valid || cur_fin) begin
          if (out_free) begin
            close_fire = 1'b1;
            close_bare = !pend_valid;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= i2p_pkg::MODE_OP;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      count <= count_next;
      if (close_fire || (emit_fire && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit_fire) begin
        pend_valid <= 1'b1;
      end else if (close_fire) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    flag_status <= flag_status_next;
    if (in_valid && in_ready) begin
      cur_char <= ch;
      cur_fin  <= end_of_expr;
    end
    if (emit_fire) begin
      pend <= emit_res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end
    if (close_fire) begin
      out_last <= cur_fin;
      if (close_bare) begin
        out_res <= '{out_char: i2p_pkg::CH_NONE, has_char: 1'b0, status: i2p_pkg::ST_OK};
      end else begin
        out_res <= pend;
      end
    end
  end

  assign out_char = out_res.out_char;
  assign has_char = out_res.has_char;
  assign status   = out_res.status;
  assign last     = out_last;

  // The stack count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // No push into a full stack, no read of an empty one
  a_no_overflow_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !stack_full)
    else $error("push into full stack");

  a_no_empty_read: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !stack_empty)
    else $error("read of empty stack");

  // The hold register is drained before a new request is taken
  a_hold_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("held result left over between requests");

  // An end request closes with an empty stack
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cur_fin) |-> stack_empty)
    else $error("stack not flushed at end of expression");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the infix to postfix converter.
module testbench;

  localparam int LIMIT_CYCLES  = 5000000;
  localparam int RANDOM_ITEMS  = 380;
  localparam int SETTLE_CYCLES = 100;

  // One postfix result as it is expected on the result channel
  typedef struct packed {
    logic [7:0]        out_char;
    logic              has_char;
    logic              last;
    i2p_pkg::status_t  status;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;
  logic [1:0] status;

  // Shadow of the operator stack
  logic [7:0] shadow_stack [i2p_pkg::STACK_DEPTH];
  int         shadow_depth = 0;

  postfix_t   pending_postfix [$];
  logic [7:0] expr_buf [$];
  int         err_count = 0;
  int         cycle_count = 0;
  int         rx_hold = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  infix_to_postfix_converter i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .end_of_expr (end_of_expr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .has_char    (has_char),
    .last        (last),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("infix_to_postfix_converter verification failed");
      $finish;
    end
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int op_level(input logic [7:0] c);
    if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH) begin
      return 2;
    end else if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS) begin
      return 1;
    end
    return 0;
  endfunction

  function automatic bit is_arith(input logic [7:0] c);
    return c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS ||
           c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH;
  endfunction

  function automatic postfix_t make_result(input logic [7:0] c, input logic h,
                                           input i2p_pkg::status_t s);
    return postfix_t'{out_char: c, has_char: h, last: 1'b0, status: s};
  endfunction

  // Work out the postfix results of one accepted character
  task automatic predict_postfix(input logic [7:0] c, input logic fin);
    postfix_t   res [$];
    logic [7:0] top;
    bit         matched;
    matched = 1'b0;
    // pop operators that bind at least as tightly
    if (is_arith(c)) begin
      while (shadow_depth > 0 && op_level(c) <= op_level(shadow_stack[shadow_depth-1])) begin
        shadow_depth--;
        res.push_back(make_result(shadow_stack[shadow_depth], 1'b1, i2p_pkg::ST_OK));
      end
    end
    if (is_arith(c) || c == i2p_pkg::CH_OPEN) begin
      if (shadow_depth >= i2p_pkg::STACK_DEPTH) begin
        res.push_back(make_result(i2p_pkg::CH_NONE, 1'b0, i2p_pkg::ST_OVERFLOW));
      end else begin
        shadow_stack[shadow_depth] = c;
        shadow_depth++;
      end
    end else if (c == i2p_pkg::CH_CLOSE) begin
      // unwind to the matching open parenthesis
      while (shadow_depth > 0 && !matched) begin
        shadow_depth--;
        top = shadow_stack[shadow_depth];
        if (top == i2p_pkg::CH_OPEN) begin
          matched = 1'b1;
        end else begin
          res.push_back(make_result(top, 1'b1, i2p_pkg::ST_OK));
        end
      end
      if (!matched) begin
        res.push_back(make_result(i2p_pkg::CH_NONE, 1'b0, i2p_pkg::ST_UNMATCHED));
      end
    end else begin
      res.push_back(make_result(c, 1'b1, i2p_pkg::ST_OK));
    end
    // flush the stack at the end of the expression
    if (fin) begin
      while (shadow_depth > 0) begin
        shadow_depth--;
        res.push_back(make_result(shadow_stack[shadow_depth], 1'b1, i2p_pkg::ST_OK));
      end
      if (res.size() == 0) begin
        res.push_back(make_result(i2p_pkg::CH_NONE, 1'b0, i2p_pkg::ST_OK));
      end
      res[res.size()-1].last = 1'b1;
    end
    foreach (res[i]) begin
      pending_postfix.push_back(res[i]);
    end
  endtask

  // Send one character; called and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    ch          = c;
    end_of_expr = fin;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_postfix(c, fin);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], fin && (i == s.len() - 1));
    end
  endtask

  // Hold the sender until every expected result is in
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_postfix.size() != 0) @(negedge clk);
  endtask

  // Drive out_ready with random stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      out_ready = 1'b1;
      if (!rx_calm && $urandom_range(0, 2) == 0) begin
        rx_hold = pick_gap(1'b0);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    postfix_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_postfix.size() == 0) begin
        $display({"%0t: unexpected result: expected none, ",
                  "actual out_char=%h has_char=%b last=%b status=%0d"},
                 $time, out_char, has_char, last, status);
        err_count++;
      end else begin
        want = pending_postfix.pop_front();
        check_field("out_char", want.out_char, out_char);
        check_field("has_char", want.has_char, has_char);
        check_field("last", want.last, last);
        check_field("status", want.status, status);
      end
    end
  end

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return i2p_pkg::CH_PLUS;
      1:       return i2p_pkg::CH_MINUS;
      2:       return i2p_pkg::CH_STAR;
      default: return i2p_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 2))
      0:       return i2p_pkg::CH_OPEN;
      1:       return i2p_pkg::CH_CLOSE;
      default: return pick_op();
    endcase
  endfunction

  // Operand: mostly letters and digits, sometimes any plain byte
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    int         r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 8'h61 + 8'($urandom_range(0, 25));
    end else if (r < 8) begin
      return 8'h30 + 8'($urandom_range(0, 9));
    end
    do c = 8'($urandom_range(0, 255));
    while (is_arith(c) || c == i2p_pkg::CH_OPEN || c == i2p_pkg::CH_CLOSE);
    return c;
  endfunction

  // Append a well-formed expression with nesting up to depth
  function automatic void gen_expr(input int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        expr_buf.push_back(pick_op());
      end
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_buf.push_back(i2p_pkg::CH_OPEN);
        gen_expr(depth - 1);
        expr_buf.push_back(i2p_pkg::CH_CLOSE);
      end else begin
        expr_buf.push_back(pick_operand());
      end
    end
  endfunction

  task automatic test_operands();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  task automatic test_operators();
    send_text("a-b/c*d+e", 1'b1);
    send_text("+", 1'b1);
  endtask

  task automatic test_parentheses();
    send_text("(a-b)/c", 1'b1);
    // matched pair with nothing left to emit ends on a bare marker
    send_text("()", 1'b1);
    // open parenthesis left over is flushed like an operator
    send_text("(x", 1'b1);
  endtask

  task automatic test_unmatched_close();
    send_text("a*b)", 1'b1);
    send_text(")", 1'b1);
  endtask

  // Fill the stack, overflow it twice, then flush the most results one item gives
  task automatic test_overflow();
    drain_results();
    repeat (i2p_pkg::STACK_DEPTH + 1) send_char(i2p_pkg::CH_OPEN, 1'b0);
    send_char(i2p_pkg::CH_STAR, 1'b0);
    send_char("z", 1'b1);
  endtask

  task automatic test_random_expressions();
    int sent;
    int kind;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 6) == 0);
      rx_calm = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0) begin
        drain_results();
      end
      expr_buf.delete();
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        if (kind < 14) begin
          gen_expr(3);
        end else begin
          // broken expression: clobber one character, maybe add a stray close
          gen_expr(2);
          expr_buf[$urandom_range(0, expr_buf.size() - 1)] = pick_special();
          if ($urandom_range(0, 1) == 1) begin
            expr_buf.push_back(i2p_pkg::CH_CLOSE);
          end
        end
        foreach (expr_buf[i]) begin
          send_char(expr_buf[i], i == expr_buf.size() - 1);
        end
        sent += expr_buf.size();
      end else if (kind < 18) begin
        // noise: raw bytes with random end markers
        repeat ($urandom_range(1, 8)) begin
          send_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_special(),
                    $urandom_range(0, 3) == 0);
          sent++;
        end
      end else begin
        // deep nesting around the stack limit
        repeat ($urandom_range(i2p_pkg::STACK_DEPTH - 8, i2p_pkg::STACK_DEPTH + 4)) begin
          expr_buf.push_back(i2p_pkg::CH_OPEN);
        end
        gen_expr(1);
        repeat ($urandom_range(0, 3)) expr_buf.push_back(i2p_pkg::CH_CLOSE);
        foreach (expr_buf[i]) begin
          send_char(expr_buf[i], i == expr_buf.size() - 1);
        end
        sent += expr_buf.size();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_operands();
    test_operators();
    test_parentheses();
    test_unmatched_close();
    test_overflow();
    test_random_expressions();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("infix_to_postfix_converter verification clean");
    end else begin
      $display("infix_to_postfix_converter verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/i2p_pkg.sv
design/i2p_ram.sv
design/infix_to_postfix_converter.sv
tb/sv/testbench.sv
